### src/dts_pkg.sv
`timescale 1ns / 1ps

package dts_pkg;

	localparam int CHAR_W               = 8;
	localparam int COUNT_W              = 16;
	localparam int DLEN_W               = 4;
	localparam int DBYTES_W             = 64;
	localparam int CFG_IDX_W            = 1;
	localparam int CFG_DATA_W           = 64;
	localparam int MAX_DELIM_BYTES_DEF  = 8;

	localparam logic [COUNT_W-1:0]   COUNT_MAX       = 16'hFFFF;
	localparam logic [DLEN_W-1:0]    DLEN_RESET      = 4'd1;
	localparam logic [DBYTES_W-1:0]  DBYTES_RESET    = 64'd44;

	// register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] REG_DELIM_LENGTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_DELIM_BYTES  = 1'b1;

	// controller -> datapath
	typedef struct packed {
		logic append;      // store incoming byte at window tail
		logic decide;      // resolve window head: boundary or token byte
		logic flush_byte;  // emit window head as token byte
		logic flush_end;   // emit closing result, clear string state
	} dts_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic ready_len;   // window holds at least a full delimiter
		logic last_decide; // current decision leaves window short
		logic pend_zero;   // window empty
		logic slot_free;   // output register can take a word
	} dts_status_t;

endpackage

### src/dts_if.sv
`timescale 1ns / 1ps

interface dts_in_if;
	import dts_pkg::*;
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_value;
	logic              end_of_string;

	modport source (output valid, output char_value, output end_of_string, input ready);
	modport sink   (input valid, input char_value, input end_of_string, output ready);
endinterface

interface dts_out_if;
	import dts_pkg::*;
	logic               valid;
	logic               ready;
	logic [CHAR_W-1:0]  token_byte;
	logic               byte_valid;
	logic               token_end;
	logic               string_end;
	logic [COUNT_W-1:0] token_count;
	logic               last_of_run;

	modport source (output valid, output token_byte, output byte_valid, output token_end,
		output string_end, output token_count, output last_of_run, input ready);
	modport sink   (input valid, input token_byte, input byte_valid, input token_end,
		input string_end, input token_count, input last_of_run, output ready);
endinterface

interface dts_cfg_if;
	import dts_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  reg_index;
	logic [CFG_DATA_W-1:0] write_data;

	modport source (output valid, output reg_index, output write_data, input ready);
	modport sink   (input valid, input reg_index, input write_data, output ready);
endinterface

### src/dts_datapath.sv
`timescale 1ns / 1ps

module dts_datapath #(
	parameter int MAX_DELIMITER_BYTES = dts_pkg::MAX_DELIM_BYTES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [dts_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dts_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic [dts_pkg::CHAR_W-1:0]     char_value,
	input  dts_pkg::dts_cmd_t              cmd,
	output dts_pkg::dts_status_t           status,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic [dts_pkg::CHAR_W-1:0]     token_byte,
	output logic                           byte_valid,
	output logic                           token_end,
	output logic                           string_end,
	output logic [dts_pkg::COUNT_W-1:0]    token_count,
	output logic                           last_of_run
);
	import dts_pkg::*;

	localparam int PEND_W = $clog2(MAX_DELIMITER_BYTES + 1);
	localparam int WIN_W  = MAX_DELIMITER_BYTES * CHAR_W;

	logic [DLEN_W-1:0]   dlen_q;
	logic [DBYTES_W-1:0] dbytes_q;
	logic [WIN_W-1:0]    win_q;      // oldest byte in low bits
	logic [PEND_W-1:0]   pend_q;
	logic [COUNT_W-1:0]  cnt_q;

	logic                out_valid_q;
	logic [CHAR_W-1:0]   tok_byte_q;
	logic                byte_valid_q;
	logic                token_end_q;
	logic                string_end_q;
	logic [COUNT_W-1:0]  token_count_q;
	logic                last_q;

	logic [PEND_W-1:0]   len_eff;
	logic                match;
	logic [PEND_W-1:0]   drop;
	logic [PEND_W-1:0]   pend_after;
	logic [COUNT_W-1:0]  cnt_inc;
	logic                emit;

	// clamp configured length into 1..MAX
	always_comb begin
		if (dlen_q == '0) begin
			len_eff = PEND_W'(1);
		end else if (dlen_q > DLEN_W'(MAX_DELIMITER_BYTES)) begin
			len_eff = PEND_W'(MAX_DELIMITER_BYTES);
		end else begin
			len_eff = dlen_q[PEND_W-1:0];
		end
	end

	always_comb begin
		match = 1'b1;
		for (int i = 0; i < MAX_DELIMITER_BYTES; i++) begin
			if ((PEND_W'(i) < len_eff) && (win_q[i*CHAR_W +: CHAR_W] != dbytes_q[i*CHAR_W +: CHAR_W]))
				match = 1'b0;
		end
	end

	assign drop       = match ? len_eff : PEND_W'(1);
	assign pend_after = pend_q - drop;
	assign cnt_inc    = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + 1'b1;
	assign emit       = cmd.decide | cmd.flush_byte | cmd.flush_end;

	assign status.ready_len   = (pend_q >= len_eff);
	assign status.last_decide = (pend_after < len_eff);
	assign status.pend_zero   = (pend_q == '0);
	assign status.slot_free   = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dlen_q   <= DLEN_RESET;
			dbytes_q <= DBYTES_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DELIM_LENGTH: dlen_q   <= cfg_data[DLEN_W-1:0];
				REG_DELIM_BYTES:  dbytes_q <= cfg_data[DBYTES_W-1:0];
			endcase
		end
	end

	// window contents: no reset, only the pending bytes are ever read
	always_ff @(posedge clk) begin
		if (cmd.append) begin
			for (int i = 0; i < MAX_DELIMITER_BYTES; i++) begin
				if (pend_q == PEND_W'(i))
					win_q[i*CHAR_W +: CHAR_W] <= char_value;
			end
		end else if (cmd.decide) begin
			win_q <= win_q >> {drop, 3'b000};
		end else if (cmd.flush_byte) begin
			win_q <= win_q >> CHAR_W;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			cnt_q  <= '0;
		end else if (cmd.append) begin
			pend_q <= pend_q + 1'b1;
		end else if (cmd.decide) begin
			pend_q <= pend_after;
			if (match)
				cnt_q <= cnt_inc;
		end else if (cmd.flush_byte) begin
			pend_q <= pend_q - 1'b1;
		end else if (cmd.flush_end) begin
			pend_q <= '0;
			cnt_q  <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			tok_byte_q    <= match ? '0 : win_q[CHAR_W-1:0];
			byte_valid_q  <= !match;
			token_end_q   <= match;
			string_end_q  <= 1'b0;
			token_count_q <= '0;
			last_q        <= status.last_decide;
		end else if (cmd.flush_byte) begin
			tok_byte_q    <= win_q[CHAR_W-1:0];
			byte_valid_q  <= 1'b1;
			token_end_q   <= 1'b0;
			string_end_q  <= 1'b0;
			token_count_q <= '0;
			last_q        <= 1'b0;
		end else if (cmd.flush_end) begin
			tok_byte_q    <= '0;
			byte_valid_q  <= 1'b0;
			token_end_q   <= 1'b1;
			string_end_q  <= 1'b1;
			token_count_q <= cnt_inc;
			last_q        <= 1'b1;
		end
	end

	assign out_valid   = out_valid_q;
	assign token_byte  = tok_byte_q;
	assign byte_valid  = byte_valid_q;
	assign token_end   = token_end_q;
	assign string_end  = string_end_q;
	assign token_count = token_count_q;
	assign last_of_run = last_q;

endmodule

### src/dts_ctrl.sv
`timescale 1ns / 1ps

module dts_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_eos,
	output logic                 in_ready,
	input  dts_pkg::dts_status_t status,
	output dts_pkg::dts_cmd_t    cmd
);
	import dts_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_DECIDE = 2'd1;
	localparam logic [1:0] ST_FLUSH  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_eos) begin
						state_d = ST_FLUSH;
					end else begin
						cmd.append = 1'b1;
						state_d    = ST_DECIDE;
					end
				end
			end
			ST_DECIDE: begin
				// one head decision per cycle while the output slot is free, until the window is short
				if (!status.ready_len) begin
					state_d = ST_IDLE;
				end else if (status.slot_free) begin
					cmd.decide = 1'b1;
					if (status.last_decide)
						state_d = ST_IDLE;
				end
			end
			ST_FLUSH: begin
				if (status.slot_free) begin
					if (status.pend_zero) begin
						cmd.flush_end = 1'b1;
						state_d       = ST_IDLE;
					end else begin
						cmd.flush_byte = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### src/delimiter_token_splitter_unit.sv
`timescale 1ns / 1ps

// Delimiter token splitter.
// in_ch  : one word per string byte (char_value), or a terminator word with
//          end_of_string set. Bytes are split into tokens at each
//          left-to-right, non-overlapping match of the delimiter.
// out_ch : one word per result: a token byte (byte_valid) or a token
//          boundary (token_end). The terminator's final word carries
//          string_end and the saturating token count; last_of_run marks the
//          last word caused by each input word.
// cfg_ch : reg_index 0 = delimiter length (1..8), 1 = packed delimiter bytes
//          (first byte in bits 7:0). Write only while the block is idle.
// Timing: a byte word is accepted, then its window heads are decided; the
//   controller resolves one window head per cycle while the output slot is
//   free. A terminator flushes each pending byte, then emits its close word.
//   Results are registered: a word is presented in the cycle after its deciding step.
// Stall: the output register holds its word while out_ch.ready is low; the
//   controller waits on that one slot, input is taken again once idle.
// Reset: window and token counter empty, length 1, delimiter ','.
module delimiter_token_splitter_unit #(
	parameter int MAX_DELIMITER_BYTES = dts_pkg::MAX_DELIM_BYTES_DEF
) (
	input logic        clk,
	input logic        arst_n,
	dts_in_if.sink     in_ch,
	dts_out_if.source  out_ch,
	dts_cfg_if.sink    cfg_ch
);
	import dts_pkg::*;

	dts_cmd_t    cmd;
	dts_status_t status;

	// config is always taken; it lands in datapath registers directly
	assign cfg_ch.ready = 1'b1;

	dts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_eos   (in_ch.end_of_string),
		.in_ready (in_ch.ready),
		.status   (status),
		.cmd      (cmd)
	);

	dts_datapath #(
		.MAX_DELIMITER_BYTES (MAX_DELIMITER_BYTES)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_ch.valid),
		.cfg_index   (cfg_ch.reg_index),
		.cfg_data    (cfg_ch.write_data),
		.char_value  (in_ch.char_value),
		.cmd         (cmd),
		.status      (status),
		.out_ready   (out_ch.ready),
		.out_valid   (out_ch.valid),
		.token_byte  (out_ch.token_byte),
		.byte_valid  (out_ch.byte_valid),
		.token_end   (out_ch.token_end),
		.string_end  (out_ch.string_end),
		.token_count (out_ch.token_count),
		.last_of_run (out_ch.last_of_run)
	);

	// at most one datapath action per cycle
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.append, cmd.decide, cmd.flush_byte, cmd.flush_end}))
		else $error("more than one datapath command");

	// a result is only produced into a free output slot
	a_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.decide || cmd.flush_byte || cmd.flush_end) |-> status.slot_free)
		else $error("result issued into occupied output register");

	// the closing step presents a final, last-of-run word next cycle
	a_close_word: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush_end |=> (out_ch.valid && out_ch.string_end && out_ch.last_of_run))
		else $error("terminator close word missing");

	// no input is taken while a window decision or flush is in progress
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.decide || cmd.flush_byte || cmd.flush_end) |-> !in_ch.ready)
		else $error("input accepted while busy");

endmodule

### dv/tb_delimiter_token_splitter_unit.sv
`timescale 1ns / 1ps

module tb_delimiter_token_splitter_unit;
	import dts_pkg::*;

	localparam int SINK_HOLD_CYCLES = 400;   // long receiver hold-off, fills the block
	localparam int SETTLE_CYCLES    = 16;    // block latency margin once drained
	localparam int IDLE_LIMIT       = 4000;  // watchdog: cycles with no word moved
	localparam int RANDOM_ITEMS     = 390;

	// One output word as the block presents it.
	typedef struct packed {
		logic [CHAR_W-1:0]  token_byte;
		logic               byte_valid;
		logic               token_end;
		logic               string_end;
		logic [COUNT_W-1:0] token_count;
		logic               last_of_run;
	} split_word_t;

	// Shadow splitter plus the queue of words it predicts.
	class split_scoreboard;
		logic [CHAR_W-1:0]   held[MAX_DELIM_BYTES_DEF];
		int                  held_cnt;
		logic [COUNT_W-1:0]  match_cnt;
		logic [DLEN_W-1:0]   dlen;
		logic [DBYTES_W-1:0] dbytes;
		split_word_t         expected_words[$];
		int                  errors;

		function new();
			held_cnt  = 0;
			match_cnt = '0;
			dlen      = DLEN_RESET;
			dbytes    = DBYTES_RESET;
			errors    = 0;
		endfunction

		// zero length acts as one, anything past the window size as the window size
		function int eff_len();
			if (dlen == 0)
				return 1;
			if (dlen > MAX_DELIM_BYTES_DEF)
				return MAX_DELIM_BYTES_DEF;
			return int'(dlen);
		endfunction

		function logic [CHAR_W-1:0] delim_byte(int k);
			return dbytes[8*k +: 8];
		endfunction

		function int pending();
			return expected_words.size();
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == REG_DELIM_LENGTH)
				dlen = data[DLEN_W-1:0];
			else if (idx == REG_DELIM_BYTES)
				dbytes = data;
		endfunction

		function void drop_head(int n);
			for (int i = 0; i + n < held_cnt; i++)
				held[i] = held[i+n];
			held_cnt -= n;
		endfunction

		function void note_input(logic [CHAR_W-1:0] ch, logic eos);
			split_word_t run[$];
			split_word_t w;
			int          len;
			int          total;
			bit          hit;
			len = eff_len();
			if (eos) begin
				// flush the window as plain bytes, then close the string
				for (int i = 0; i < held_cnt; i++) begin
					w            = '0;
					w.token_byte = held[i];
					w.byte_valid = 1'b1;
					run.push_back(w);
				end
				total = int'(match_cnt) + 1;
				if (total > int'(COUNT_MAX))
					total = int'(COUNT_MAX);
				w             = '0;
				w.token_end   = 1'b1;
				w.string_end  = 1'b1;
				w.token_count = total[COUNT_W-1:0];
				run.push_back(w);
				held_cnt  = 0;
				match_cnt = '0;
			end else begin
				if (held_cnt < MAX_DELIM_BYTES_DEF) begin
					held[held_cnt] = ch;
					held_cnt++;
				end
				// decide heads while a full delimiter length is held
				while (held_cnt >= len && run.size() < MAX_DELIM_BYTES_DEF) begin
					hit = 1'b1;
					for (int k = 0; k < len; k++)
						if (held[k] != dbytes[8*k +: 8])
							hit = 1'b0;
					w = '0;
					if (hit) begin
						w.token_end = 1'b1;
						if (match_cnt != COUNT_MAX)
							match_cnt++;
						drop_head(len);
					end else begin
						w.token_byte = held[0];
						w.byte_valid = 1'b1;
						drop_head(1);
					end
					run.push_back(w);
				end
			end
			if (run.size() > 0)
				run[run.size()-1].last_of_run = 1'b1;
			foreach (run[i])
				expected_words.push_back(run[i]);
		endfunction

		function void check_result(split_word_t got);
			split_word_t exp_w;
			if (expected_words.size() == 0) begin
				$error("output word with nothing expected: %p", got);
				errors++;
				return;
			end
			exp_w = expected_words.pop_front();
			if (got.token_byte !== exp_w.token_byte) begin
				$error("token_byte: expected %0h, got %0h", exp_w.token_byte, got.token_byte);
				errors++;
			end
			if (got.byte_valid !== exp_w.byte_valid) begin
				$error("byte_valid: expected %0b, got %0b", exp_w.byte_valid, got.byte_valid);
				errors++;
			end
			if (got.token_end !== exp_w.token_end) begin
				$error("token_end: expected %0b, got %0b", exp_w.token_end, got.token_end);
				errors++;
			end
			if (got.string_end !== exp_w.string_end) begin
				$error("string_end: expected %0b, got %0b", exp_w.string_end, got.string_end);
				errors++;
			end
			if (got.token_count !== exp_w.token_count) begin
				$error("token_count: expected %0d, got %0d", exp_w.token_count, got.token_count);
				errors++;
			end
			if (got.last_of_run !== exp_w.last_of_run) begin
				$error("last_of_run: expected %0b, got %0b", exp_w.last_of_run, got.last_of_run);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	dts_in_if  in_ch();
	dts_out_if out_ch();
	dts_cfg_if cfg_ch();

	delimiter_token_splitter_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch)
	);

	split_scoreboard splitter = new();

	bit src_gaps_on;    // sender inserts idle cycles between words
	bit sink_gaps_on;   // receiver drops ready at random
	bit sink_hold_req;  // one-shot request for a long receiver hold-off
	int sink_wait;
	int random_items;
	int idle_cycles;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Mostly back-to-back, some short gaps, an occasional long one.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Offer one input word and hold it until the block takes it. valid stays
	// high across back-to-back words; it only drops when a gap is inserted.
	task automatic send_word(input logic [CHAR_W-1:0] ch, input logic eos);
		int gap;
		gap = src_gaps_on ? pick_gap() : 0;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid         <= 1'b1;
		in_ch.char_value    <= ch;
		in_ch.end_of_string <= eos;
		do @(posedge clk); while (!in_ch.ready);
		splitter.note_input(ch, eos);
	endtask

	task automatic cfg_word(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_ch.valid      <= 1'b1;
		cfg_ch.reg_index  <= idx;
		cfg_ch.write_data <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		splitter.write_reg(idx, data);
	endtask

	// Write either or both registers, then release the config channel.
	task automatic load_delimiter(input bit wr_len, input logic [CFG_DATA_W-1:0] len_word,
		input bit wr_bytes, input logic [CFG_DATA_W-1:0] delim);
		if (wr_len)
			cfg_word(REG_DELIM_LENGTH, len_word);
		if (wr_bytes)
			cfg_word(REG_DELIM_BYTES, delim);
		cfg_ch.valid <= 1'b0;
	endtask

	// Stop offering input, wait for every predicted word, then give the block
	// time to finish a byte that produced nothing.
	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (splitter.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Random text built mostly from delimiter material so matches are common:
	// whole delimiters, cut-off prefixes, loose delimiter bytes, plus noise.
	task automatic send_random_text(input int n_bytes, input bit close);
		int sent;
		int len;
		int piece;
		int cut;
		sent = 0;
		len  = splitter.eff_len();
		while (sent < n_bytes) begin
			piece = $urandom_range(0, 99);
			if (piece < 30) begin
				for (int k = 0; k < len; k++)
					send_word(splitter.delim_byte(k), 1'b0);
				sent += len;
			end else if (piece < 45 && len > 1) begin
				cut = $urandom_range(1, len - 1);
				for (int k = 0; k < cut; k++)
					send_word(splitter.delim_byte(k), 1'b0);
				sent += cut;
			end else if (piece < 80) begin
				send_word(splitter.delim_byte($urandom_range(0, len - 1)), 1'b0);
				sent++;
			end else begin
				send_word(8'($urandom_range(0, 255)), 1'b0);
				sent++;
			end
		end
		// char_value of a terminator is don't-care, so it carries noise
		if (close)
			send_word(8'($urandom_range(0, 255)), 1'b1);
		random_items += sent + int'(close);
	endtask

	// Receiver: checks every word taken, and paces ready on its own count.
	initial begin : result_sink
		split_word_t got;
		out_ch.ready <= 1'b0;
		sink_wait = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready) begin
				got.token_byte  = out_ch.token_byte;
				got.byte_valid  = out_ch.byte_valid;
				got.token_end   = out_ch.token_end;
				got.string_end  = out_ch.string_end;
				got.token_count = out_ch.token_count;
				got.last_of_run = out_ch.last_of_run;
				splitter.check_result(got);
			end
			if (sink_hold_req) begin
				sink_hold_req = 1'b0;
				sink_wait     = SINK_HOLD_CYCLES;
			end
			if (sink_wait > 0) begin
				out_ch.ready <= 1'b0;
				sink_wait--;
			end else begin
				out_ch.ready <= 1'b1;
				if (sink_gaps_on)
					sink_wait = pick_gap();
			end
		end
	end

	// Watchdog: any word on any channel resets the count.
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
			|| (cfg_ch.valid && cfg_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin : stimulus
		int                  phase;
		int                  len_roll;
		logic [DLEN_W-1:0]   len_field;
		logic [CFG_DATA_W-1:0] delim;
		arst_n              <= 1'b0;
		in_ch.valid         <= 1'b0;
		in_ch.char_value    <= '0;
		in_ch.end_of_string <= 1'b0;
		cfg_ch.valid        <= 1'b0;
		cfg_ch.reg_index    <= REG_DELIM_LENGTH;
		cfg_ch.write_data   <= '0;
		src_gaps_on   = 1'b1;
		sink_gaps_on  = 1'b1;
		sink_hold_req = 1'b0;
		random_items  = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed, reset delimiter ',' ---
		// empty string: terminator alone closes one token
		send_word(8'hA5, 1'b1);
		// extreme bytes and adjacent delimiters (empty token)
		send_word(8'h00, 1'b0);
		send_word(8'h2C, 1'b0);
		send_word(8'h2C, 1'b0);
		send_word(8'hFF, 1'b0);
		send_word(8'h61, 1'b0);
		send_word(8'h00, 1'b1);
		wait_drained();

		// three-byte "<->": false start, full match, then a cut-off prefix that
		// the terminator flushes as plain bytes
		load_delimiter(1'b1, 64'd3, 1'b1, 64'h3E2D3C);
		send_word(8'h3C, 1'b0);
		send_word(8'h3C, 1'b0);
		send_word(8'h2D, 1'b0);
		send_word(8'h3E, 1'b0);
		send_word(8'h3C, 1'b0);
		send_word(8'h2D, 1'b0);
		send_word(8'hFF, 1'b1);
		wait_drained();

		// widest delimiter: seven held bytes flushed, eight words from one item
		load_delimiter(1'b1, 64'd8, 1'b1, '1);
		repeat (7) send_word(8'hFF, 1'b0);
		send_word(8'h00, 1'b1);
		wait_drained();

		// length cut mid-string: seven bytes held under length 8, then length 1
		// makes the next byte resolve the whole window at once
		repeat (7) send_word(8'hFF, 1'b0);
		wait_drained();
		load_delimiter(1'b1, 64'd1, 1'b0, '0);
		send_word(8'h00, 1'b0);
		send_word(8'h00, 1'b1);
		wait_drained();

		// --- random phases ---
		// first phase uses length 0, second 15, fourth runs the long hold-off;
		// some phases leave a string open across the next register write
		phase = 0;
		while (random_items < RANDOM_ITEMS) begin
			len_roll = $urandom_range(0, 9);
			if (phase == 0)
				len_field = 4'd0;
			else if (phase == 1)
				len_field = 4'hF;
			else if (len_roll == 0)
				len_field = 4'd0;
			else if (len_roll == 1)
				len_field = 4'($urandom_range(9, 15));
			else
				len_field = 4'($urandom_range(1, 8));
			case ($urandom_range(0, 9))
				0:       delim = '0;
				1:       delim = '1;
				default: delim = {$urandom, $urandom};
			endcase
			if (phase < 2 || $urandom_range(0, 3) != 0)
				load_delimiter(phase < 2 || $urandom_range(0, 2) != 0,
					{$urandom, 28'($urandom), len_field},
					phase < 2 || $urandom_range(0, 2) != 0, delim);

			src_gaps_on  = $urandom_range(0, 3) != 0;
			sink_gaps_on = $urandom_range(0, 3) != 0;
			if (phase == 3) begin
				src_gaps_on   = 1'b0;
				sink_hold_req = 1'b1;
				send_random_text(40, 1'b1);
			end
			repeat ($urandom_range(1, 3))
				send_random_text($urandom_range(0, 16), 1'b1);
			if ($urandom_range(0, 2) == 0)
				send_random_text($urandom_range(1, 9), 1'b0);
			wait_drained();
			phase++;
		end

		if (splitter.errors == 0 && splitter.pending() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
